/* rtl/rcm_pkg.sv */
// Shared types and constants for the RC channel scale and thrust mix unit.
package rcm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SERVO1_MIN = 3'd0;
  localparam logic [2:0] REG_SERVO1_MAX = 3'd1;
  localparam logic [2:0] REG_SERVO2_MIN = 3'd2;
  localparam logic [2:0] REG_SERVO2_MAX = 3'd3;
  localparam logic [2:0] REG_THRUST_MIN = 3'd4;
  localparam logic [2:0] REG_THRUST_MAX = 3'd5;
  localparam logic [2:0] REG_STEER_MIN  = 3'd6;
  localparam logic [2:0] REG_STEER_MAX  = 3'd7;

  // Register reset values
  localparam logic [11:0] RST_SERVO1_MIN = 12'd1000;
  localparam logic [11:0] RST_SERVO1_MAX = 12'd2000;
  localparam logic [11:0] RST_SERVO2_MIN = 12'd1100;
  localparam logic [11:0] RST_SERVO2_MAX = 12'd1900;
  localparam logic [11:0] RST_THRUST_MIN = 12'd800;
  localparam logic [11:0] RST_THRUST_MAX = 12'd2100;
  localparam logic [11:0] RST_STEER_MIN  = 12'd910;
  localparam logic [11:0] RST_STEER_MAX  = 12'd2200;

  // Cycles from an accepted frame to its result strobe
  localparam int PIPE_LAT = 16;

  typedef struct packed {
    logic [11:0] servo1_pulse;
    logic [11:0] servo2_pulse;
    logic [11:0] thrust_pulse;
    logic [11:0] steer_pulse;
  } frame_t;

  typedef struct packed {
    logic [10:0]       servo1_cmd;
    logic [10:0]       servo2_cmd;
    logic [7:0]        thrust_left;
    logic [7:0]        thrust_right;
    logic signed [7:0] steer_level;
  } result_t;

endpackage

/* rtl/rcm_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module rcm_div_pipe #(
  parameter int N_W = 23,
  parameter int D_W = 14,
  parameter int Q_W = 10,
  parameter int T_W = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  input  logic [T_W-1:0] in_tag,
  output logic           out_valid,
  output logic [Q_W-1:0] quot,
  output logic [T_W-1:0] out_tag
);

  localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [CW-1:0]  rem   [Q_W+1];
  logic [D_W-1:0] dsr   [Q_W+1];
  logic [Q_W-1:0] qacc  [Q_W+1];
  logic [T_W-1:0] tag   [Q_W+1];
  logic           vld   [Q_W+1];

  assign rem[0]  = CW'(num);
  assign dsr[0]  = den;
  assign qacc[0] = '0;
  assign tag[0]  = in_tag;
  assign vld[0]  = in_valid;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [CW-1:0] sh;
    logic          fit;

    // test one quotient bit against the shifted divisor
    assign sh  = CW'(dsr[k]) << B;
    assign fit = rem[k] >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= fit ? rem[k] - sh : rem[k];
      qacc[k+1] <= fit ? (qacc[k] | (Q_W'(1) << B)) : qacc[k];
      dsr[k+1]  <= dsr[k];
      tag[k+1]  <= tag[k];
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = qacc[Q_W];
  assign out_tag   = tag[Q_W];

endmodule

/* rtl/rc_channel_scale_and_thrust_mix_unit.sv */
// Top level of the RC channel scale and thrust mix unit.
// A frame is taken whenever start is high (busy is always low), one frame per
// clock, and its result appears on result with done high for one cycle; the
// receiver cannot stall, so every result must be captured in its strobe cycle.
// The pipeline is the ten-stage restoring dividers (one quotient bit per stage)
// plus input, clamp, scale and three mix stages. The user must write the
// configuration registers via cfg_we/cfg_index/cfg_data only while no frame is
// in flight; the block does not enforce it. No clearing pass runs after reset.
module rc_channel_scale_and_thrust_mix_unit #(
  parameter int DEADBAND = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  rcm_pkg::frame_t frame,
  output logic            done,
  output rcm_pkg::result_t result,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [11:0]     cfg_data
);

  localparam int N_W = 23;
  localparam int D_W = 14;
  localparam int Q_W = 10;
  localparam int MD  = 100 - DEADBAND;
  localparam int RK  = 24;
  localparam logic [24:0] RECIP = 25'(((64'd1 << RK) + 64'(MD) - 64'd1) / 64'(MD));
  localparam logic signed [8:0] DB_S = 9'(DEADBAND);

  typedef struct packed {
    logic [12:0] off;
    logic [12:0] rng;
  } span_t;

  // Clamp a pulse into its effective bounds; give offset and range
  function automatic span_t clamp_span(input logic [11:0] p, input logic [11:0] lo,
                                       input logic [11:0] hi);
    logic signed [13:0] mn;
    logic signed [13:0] mx;
    logic signed [13:0] v;
    span_t sp;
    mx = $signed({2'b00, hi});
    mn = (lo >= hi) ? mx - 14'sd1 : $signed({2'b00, lo});
    v  = $signed({2'b00, p});
    if (v < mn) v = mn;
    if (v > mx) v = mx;
    sp.off = 13'(v - mn);
    sp.rng = 13'(mx - mn);
    return sp;
  endfunction

  assign busy = 1'b0;

  // Configuration registers
  logic [11:0] servo1_min, servo1_max, servo2_min, servo2_max;
  logic [11:0] thrust_min, thrust_max, steer_min, steer_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo1_min <= rcm_pkg::RST_SERVO1_MIN;
      servo1_max <= rcm_pkg::RST_SERVO1_MAX;
      servo2_min <= rcm_pkg::RST_SERVO2_MIN;
      servo2_max <= rcm_pkg::RST_SERVO2_MAX;
      thrust_min <= rcm_pkg::RST_THRUST_MIN;
      thrust_max <= rcm_pkg::RST_THRUST_MAX;
      steer_min  <= rcm_pkg::RST_STEER_MIN;
      steer_max  <= rcm_pkg::RST_STEER_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        rcm_pkg::REG_SERVO1_MIN: servo1_min <= cfg_data;
        rcm_pkg::REG_SERVO1_MAX: servo1_max <= cfg_data;
        rcm_pkg::REG_SERVO2_MIN: servo2_min <= cfg_data;
        rcm_pkg::REG_SERVO2_MAX: servo2_max <= cfg_data;
        rcm_pkg::REG_THRUST_MIN: thrust_min <= cfg_data;
        rcm_pkg::REG_THRUST_MAX: thrust_max <= cfg_data;
        rcm_pkg::REG_STEER_MIN:  steer_min  <= cfg_data;
        rcm_pkg::REG_STEER_MAX:  steer_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid chain outside the dividers
  logic v0, va, vb, vm1, vm2, vm3;
  logic dv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      va  <= 1'b0;
      vb  <= 1'b0;
      vm1 <= 1'b0;
      vm2 <= 1'b0;
      vm3 <= 1'b0;
    end else begin
      v0  <= start & ~busy;
      va  <= v0;
      vb  <= va;
      vm1 <= dv1;
      vm2 <= vm1;
      vm3 <= vm2;
    end
  end

  // Capture the frame on transfer
  rcm_pkg::frame_t fr0;
  always_ff @(posedge clk) begin
    fr0 <= frame;
  end

  // Clamp each channel and find its offset and range
  span_t a1, a2, a3, a4;
  logic [12:0] a4_abs;
  logic        a4_neg;
  span_t s4c;
  logic signed [14:0] s4_diff;

  assign s4c     = clamp_span(fr0.steer_pulse, steer_min, steer_max);
  assign s4_diff = $signed({1'b0, s4c.off, 1'b0}) - $signed({2'b00, s4c.rng});

  always_ff @(posedge clk) begin
    a1     <= clamp_span(fr0.servo1_pulse, servo1_min, servo1_max);
    a2     <= clamp_span(fr0.servo2_pulse, servo2_min, servo2_max);
    a3     <= clamp_span(fr0.thrust_pulse, thrust_min, thrust_max);
    a4     <= s4c;
    a4_neg <= s4_diff < 15'sd0;
    a4_abs <= (s4_diff < 15'sd0) ? 13'(-s4_diff) : 13'(s4_diff);
  end

  // Form dividends and divisors
  logic [N_W-1:0] n1, n2, n3, n4;
  logic [D_W-1:0] d1, d2, d3, d4;
  logic           b_neg;

  always_ff @(posedge clk) begin
    n1    <= N_W'(a1.off) * N_W'(1000);
    n2    <= N_W'(a2.off) * N_W'(1000);
    n3    <= N_W'(a3.off) * N_W'(255);
    n4    <= N_W'(a4_abs) * N_W'(200) + N_W'(a4.rng);
    d1    <= D_W'(a1.rng);
    d2    <= D_W'(a2.rng);
    d3    <= D_W'(a3.rng);
    d4    <= {a4.rng, 1'b0};
    b_neg <= a4_neg;
  end

  // Divide the four channels in parallel pipelines; lanes run in lockstep,
  // so the first lane's valid stands for all of them
  logic [Q_W-1:0] q1, q2, q3, q4;
  logic           q4_neg;

  rcm_div_pipe #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W), .T_W(1)) u_div1 (
    .clk(clk), .rst(rst), .in_valid(vb), .num(n1), .den(d1), .in_tag(1'b0),
    .out_valid(dv1), .quot(q1), .out_tag()
  );
  rcm_div_pipe #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W), .T_W(1)) u_div2 (
    .clk(clk), .rst(rst), .in_valid(vb), .num(n2), .den(d2), .in_tag(1'b0),
    .out_valid(), .quot(q2), .out_tag()
  );
  rcm_div_pipe #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W), .T_W(1)) u_div3 (
    .clk(clk), .rst(rst), .in_valid(vb), .num(n3), .den(d3), .in_tag(1'b0),
    .out_valid(), .quot(q3), .out_tag()
  );
  rcm_div_pipe #(.N_W(N_W), .D_W(D_W), .Q_W(Q_W), .T_W(1)) u_div4 (
    .clk(clk), .rst(rst), .in_valid(vb), .num(n4), .den(d4), .in_tag(b_neg),
    .out_valid(), .quot(q4), .out_tag(q4_neg)
  );

  // Mix stage 1: steer level, mode and thrust product
  logic signed [7:0] st_c;
  logic signed [8:0] st_w;
  logic              lo_side_c, in_band_c;
  logic [7:0]        k_c;

  assign st_c      = q4_neg ? -$signed({1'b0, q4[6:0]}) : $signed({1'b0, q4[6:0]});
  assign st_w      = 9'(st_c);
  assign in_band_c = (st_w < DB_S) && (st_w >= -DB_S);
  assign lo_side_c = st_w < -DB_S;
  assign k_c       = lo_side_c ? 8'(9'sd100 + st_w) : 8'(9'sd100 - st_w);

  logic [10:0]       m1_s1, m1_s2, m2_s1, m2_s2;
  logic [7:0]        m1_t, m2_t;
  logic signed [7:0] m1_st, m2_st;
  logic              m1_band, m1_lo, m2_band, m2_lo;
  logic [15:0]       m1_prod;
  logic [40:0]       m2_prod;

  always_ff @(posedge clk) begin
    m1_s1   <= 11'(q1) + 11'd1000;
    m1_s2   <= 11'(q2) + 11'd1000;
    m1_t    <= q3[7:0];
    m1_st   <= st_c;
    m1_band <= in_band_c;
    m1_lo   <= lo_side_c;
    m1_prod <= 16'(q3[7:0]) * 16'(k_c);
  end

  // Mix stage 2: divide the product by the constant through its reciprocal
  always_ff @(posedge clk) begin
    m2_s1   <= m1_s1;
    m2_s2   <= m1_s2;
    m2_t    <= m1_t;
    m2_st   <= m1_st;
    m2_band <= m1_band;
    m2_lo   <= m1_lo;
    m2_prod <= 41'(m1_prod) * 41'(RECIP);
  end

  // Mix stage 3: pick the scaled motor and register the result
  logic [7:0] scaled;
  assign scaled = m2_prod[RK+7:RK];

  always_ff @(posedge clk) begin
    result.servo1_cmd   <= m2_s1;
    result.servo2_cmd   <= m2_s2;
    result.steer_level  <= m2_st;
    result.thrust_left  <= (!m2_band && m2_lo) ? scaled : m2_t;
    result.thrust_right <= (!m2_band && !m2_lo) ? scaled : m2_t;
  end

  assign done = vm3;

endmodule

/* rtl/rcm_checker.sv */
// Port-level checker for the RC channel scale and thrust mix unit, with its bind.
module rcm_checker #(
  parameter int DEADBAND = 10
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rcm_pkg::result_t result
);

  localparam logic signed [7:0] DB8 = 8'(DEADBAND);

  // every strobe comes from a frame taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rcm_pkg::PIPE_LAT))
    else $error("result strobe without a matching frame transfer");

  // servo commands stay in their span
  a_servo: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.servo1_cmd >= 11'd1000 && result.servo1_cmd <= 11'd2000 &&
              result.servo2_cmd >= 11'd1000 && result.servo2_cmd <= 11'd2000))
    else $error("servo command out of span");

  // steer level stays in its span
  a_steer: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.steer_level >= -8'sd100 && result.steer_level <= 8'sd100))
    else $error("steer level out of span");

  // the motor on the steering side never exceeds the other one
  a_mix: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.steer_level >= 8'sd0 && result.thrust_right <= result.thrust_left) ||
              (result.steer_level < 8'sd0 && result.thrust_left <= result.thrust_right)))
    else $error("motor mix inconsistent with steer direction");

  // inside the dead band both motors match
  a_band: assert property (@(posedge clk) disable iff (rst)
    (done && result.steer_level < DB8 && result.steer_level >= -DB8) |->
      (result.thrust_left == result.thrust_right))
    else $error("motors differ inside the dead band");

endmodule

bind rc_channel_scale_and_thrust_mix_unit rcm_checker #(.DEADBAND(DEADBAND)) u_rcm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

/* tb/rc_channel_scale_and_thrust_mix_unit_tb.sv */
// Testbench for the RC channel scale and thrust mix unit: directed table plus random frames.
`timescale 1ns / 1ps
module rc_channel_scale_and_thrust_mix_unit_tb;

  localparam int DZ = 10;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rcm_pkg::frame_t frame = '0;
  logic done;
  rcm_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  logic [11:0] bounds_q [8];
  rcm_pkg::result_t expected_q [$];
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // One directed row: frame plus an optional typed-in result
  typedef struct {
    rcm_pkg::frame_t  frm;
    bit               has_exp;
    rcm_pkg::result_t exp_res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  rc_channel_scale_and_thrust_mix_unit #(.DEADBAND(DZ)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .frame(frame),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Effective bounds and clamped value for one channel
  function automatic void clamp_chan(input logic [11:0] mn_r, input logic [11:0] mx_r,
                                     input logic [11:0] raw, output int lo,
                                     output int hi, output int v);
    lo = int'(mn_r);
    hi = int'(mx_r);
    if (lo >= hi) lo = hi - 1;
    v = int'(raw);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
  endfunction

  function automatic int scale_lin(input logic [11:0] mn_r, input logic [11:0] mx_r,
                                   input logic [11:0] raw, input int full);
    int lo, hi, v;
    clamp_chan(mn_r, mx_r, raw, lo, hi, v);
    return (v - lo) * full / (hi - lo);
  endfunction

  // Compute the mixed motor result for one frame
  function automatic rcm_pkg::result_t mix_frame(input rcm_pkg::frame_t f);
    rcm_pkg::result_t r;
    int lo, hi, v, mid2, d, t, s, left, right;
    t = scale_lin(bounds_q[rcm_pkg::REG_THRUST_MIN], bounds_q[rcm_pkg::REG_THRUST_MAX],
                  f.thrust_pulse, 255);
    clamp_chan(bounds_q[rcm_pkg::REG_STEER_MIN], bounds_q[rcm_pkg::REG_STEER_MAX],
               f.steer_pulse, lo, hi, v);
    mid2 = lo + hi;
    d = hi - lo;
    if (2 * v == mid2) s = 0;
    else if (2 * v < mid2) s = -((200 * (d - (2 * v - 2 * lo)) + d) / (2 * d));
    else s = (200 * (2 * v - mid2) + d) / (2 * d);
    left = t;
    right = t;
    if (s < -DZ) left = t * (100 + s) / (100 - DZ);
    else if (s >= DZ) right = t * (100 - s) / (100 - DZ);
    r.servo1_cmd = 11'(scale_lin(bounds_q[rcm_pkg::REG_SERVO1_MIN],
                                 bounds_q[rcm_pkg::REG_SERVO1_MAX],
                                 f.servo1_pulse, 1000) + 1000);
    r.servo2_cmd = 11'(scale_lin(bounds_q[rcm_pkg::REG_SERVO2_MIN],
                                 bounds_q[rcm_pkg::REG_SERVO2_MAX],
                                 f.servo2_pulse, 1000) + 1000);
    r.thrust_left = 8'(left);
    r.thrust_right = 8'(right);
    r.steer_level = 8'(s);
    return r;
  endfunction

  // Check each result strobe against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      cycle_cnt <= cycle_cnt + 1;
      if (done) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10) $display("unexpected result %p", result);
        end else begin
          rcm_pkg::result_t e;
          e = expected_q.pop_front();
          if (result !== e) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= 10) $display("expected %p got %p", e, result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("rc_channel_scale_and_thrust_mix_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    bounds_q[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for all results, then let the pipeline drain
  task automatic drain_pipe();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (rcm_pkg::PIPE_LAT + 4) @(negedge clk);
  endtask

  // Hold start for one transfer after the given gap; start stays high if no gap follows
  task automatic send_frame(input rcm_pkg::frame_t f, input rcm_pkg::result_t e,
                            input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    frame <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic send_mixed(input rcm_pkg::frame_t f, input bit gaps);
    send_frame(f, mix_frame(f), gaps ? $urandom_range(0, 14) : 0);
  endtask

  function automatic logic [11:0] rand_pulse(input logic [11:0] mn, input logic [11:0] mx);
    int lo, hi;
    lo = (mn < mx) ? int'(mn) : int'(mx);
    hi = (mn < mx) ? int'(mx) : int'(mn);
    case ($urandom_range(0, 5))
      0: return 12'($urandom);
      1: return 12'(lo);
      2: return 12'(hi);
      3: return 12'((lo + hi) / 2 + $urandom_range(0, 1));
      default: return 12'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic rcm_pkg::frame_t rand_frame();
    rcm_pkg::frame_t f;
    f.servo1_pulse = rand_pulse(bounds_q[rcm_pkg::REG_SERVO1_MIN],
                                bounds_q[rcm_pkg::REG_SERVO1_MAX]);
    f.servo2_pulse = rand_pulse(bounds_q[rcm_pkg::REG_SERVO2_MIN],
                                bounds_q[rcm_pkg::REG_SERVO2_MAX]);
    f.thrust_pulse = rand_pulse(bounds_q[rcm_pkg::REG_THRUST_MIN],
                                bounds_q[rcm_pkg::REG_THRUST_MAX]);
    f.steer_pulse = rand_pulse(bounds_q[rcm_pkg::REG_STEER_MIN],
                               bounds_q[rcm_pkg::REG_STEER_MAX]);
    return f;
  endfunction

  function automatic dir_row_t mk_row(input int p1, input int p2, input int p3, input int p4,
                                      input bit has_e, input int c1, input int c2,
                                      input int tl, input int tr, input int sl);
    dir_row_t row;
    row.frm = '{12'(p1), 12'(p2), 12'(p3), 12'(p4)};
    row.has_exp = has_e;
    row.exp_res = '{11'(c1), 11'(c2), 8'(tl), 8'(tr), 8'(sl)};
    return row;
  endfunction

  initial begin
    rcm_pkg::frame_t f;
    rcm_pkg::result_t e;
    int phase;
    logic [11:0] v;
    bounds_q = '{rcm_pkg::RST_SERVO1_MIN, rcm_pkg::RST_SERVO1_MAX,
                 rcm_pkg::RST_SERVO2_MIN, rcm_pkg::RST_SERVO2_MAX,
                 rcm_pkg::RST_THRUST_MIN, rcm_pkg::RST_THRUST_MAX,
                 rcm_pkg::RST_STEER_MIN, rcm_pkg::RST_STEER_MAX};
    // Reset-value rows with results read off directly; the rest go through the predictor
    dir_rows.push_back(mk_row(0, 0, 0, 0, 1, 1000, 1000, 0, 0, -100));
    dir_rows.push_back(mk_row(4095, 4095, 4095, 4095, 1, 2000, 2000, 255, 0, 100));
    dir_rows.push_back(mk_row(1000, 1100, 800, 910, 1, 1000, 1000, 0, 0, -100));
    dir_rows.push_back(mk_row(2000, 1900, 2100, 2200, 1, 2000, 2000, 255, 0, 100));
    dir_rows.push_back(mk_row(1500, 1500, 2100, 1555, 1, 1500, 1500, 255, 255, 0));
    dir_rows.push_back(mk_row(2048, 2048, 2100, 4095, 1, 2000, 2000, 255, 0, 100));
    dir_rows.push_back(mk_row(2730, 1365, 2100, 1490, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1365, 2730, 2100, 1620, 0, 0, 0, 0, 0, 0));
    for (int k = 1420; k <= 1690; k += 15)
      dir_rows.push_back(mk_row(k, k, 1400 + k / 2, k, 0, 0, 0, 0, 0, 0));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      f = dir_rows[i].frm;
      e = dir_rows[i].has_exp ? dir_rows[i].exp_res : mix_frame(f);
      send_frame(f, e, i % 3);
    end
    start <= 1'b0;
    drain_pipe();
    // Several bound settings: extremes, inverted and zero maxima, narrow spans, then random
    for (phase = 0; phase < 7; phase++) begin
      for (int r = 0; r < 8; r++) begin
        case (phase)
          0: v = (r % 2) ? 12'd4095 : 12'd0;
          1: v = (r % 2) ? 12'd0 : 12'd4095;
          2: v = (r % 2) ? 12'd0 : 12'd0;
          3: v = (r % 2) ? 12'd1 : 12'd0;
          4: v = (r % 2) ? 12'd2049 : 12'd2047;
          default: v = 12'($urandom);
        endcase
        write_reg(3'(r), v);
      end
      for (int n = 0; n < 100; n++) send_mixed(rand_frame(), (n / 25) % 2 == 0);
      start <= 1'b0;
      drain_pipe();
    end
    // Back-to-back run with the servo 1 and steer bounds back at their reset values
    write_reg(rcm_pkg::REG_SERVO1_MIN, rcm_pkg::RST_SERVO1_MIN);
    write_reg(rcm_pkg::REG_SERVO1_MAX, rcm_pkg::RST_SERVO1_MAX);
    write_reg(rcm_pkg::REG_STEER_MIN, rcm_pkg::RST_STEER_MIN);
    write_reg(rcm_pkg::REG_STEER_MAX, rcm_pkg::RST_STEER_MAX);
    for (int n = 0; n < 40; n++) send_mixed(rand_frame(), 1'b0);
    start <= 1'b0;
    drain_pipe();
    if (mismatch_cnt == 0) $display("rc_channel_scale_and_thrust_mix_unit: match");
    else $display("rc_channel_scale_and_thrust_mix_unit: mismatch");
    $finish;
  end

endmodule

/* files.f */
rtl/rcm_pkg.sv
rtl/rcm_div_pipe.sv
rtl/rc_channel_scale_and_thrust_mix_unit.sv
rtl/rcm_checker.sv
tb/rc_channel_scale_and_thrust_mix_unit_tb.sv
